>>> hdl/slpi_pkg.sv
// ----------------------------------------------------------------------------
// slpi_pkg
// Shared types and constants of the slew-limited pose integrator.
// ----------------------------------------------------------------------------
package slpi_pkg;

  localparam int unsigned MaxSteps = 24;
  localparam int unsigned IterW    = 5;

  localparam logic signed [33:0] CordicGain = 34'sd652032874;

  localparam logic [14:0] MaxLinSpeedRst = 15'd4096;
  localparam logic [18:0] MaxAngSpeedRst = 19'd16376;
  localparam logic [19:0] MaxLinAccelRst = 20'd1048575;
  localparam logic [23:0] MaxAngAccelRst = 24'd10419962;

  typedef enum logic [1:0] {
    REG_MAX_LIN_SPEED = 2'd0,
    REG_MAX_ANG_SPEED = 2'd1,
    REG_MAX_LIN_ACCEL = 2'd2,
    REG_MAX_ANG_ACCEL = 2'd3
  } reg_idx_e;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_STORE,
    OP_LOAD_DT,
    OP_MUL_LS,
    OP_SLEW_L,
    OP_MUL_AS,
    OP_SLEW_A,
    OP_MUL_TH,
    OP_HEAD,
    OP_ROT,
    OP_FIN,
    OP_MUL_DS,
    OP_MUL_LO,
    OP_MUL_HI,
    OP_POS,
    OP_LOAD_OUT
  } op_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_MUL_LS,
    S_SLEW_L,
    S_MUL_AS,
    S_SLEW_A,
    S_MUL_TH,
    S_HEAD,
    S_ROT,
    S_FIN,
    S_MUL_DS,
    S_MUL_LO,
    S_MUL_HI,
    S_POS,
    S_OUT
  } state_e;

  typedef struct packed {
    op_e              op;
    logic             sel;   // 0 selects x and cosine, 1 selects y and sine
    logic [IterW-1:0] iter;
  } dp_cmd_t;

  // Arctangent of 2^-i in units of 2^-32 turn.
  function automatic logic signed [31:0] atan_turn(input logic [IterW-1:0] idx);
    logic signed [31:0] r;
    case (idx)
      5'd0:  r = 32'sd536870912;
      5'd1:  r = 32'sd316933406;
      5'd2:  r = 32'sd167458907;
      5'd3:  r = 32'sd85004756;
      5'd4:  r = 32'sd42667331;
      5'd5:  r = 32'sd21354465;
      5'd6:  r = 32'sd10679838;
      5'd7:  r = 32'sd5340245;
      5'd8:  r = 32'sd2670163;
      5'd9:  r = 32'sd1335087;
      5'd10: r = 32'sd667544;
      5'd11: r = 32'sd333772;
      5'd12: r = 32'sd166886;
      5'd13: r = 32'sd83443;
      5'd14: r = 32'sd41722;
      5'd15: r = 32'sd20861;
      5'd16: r = 32'sd10430;
      5'd17: r = 32'sd5215;
      5'd18: r = 32'sd2608;
      5'd19: r = 32'sd1304;
      5'd20: r = 32'sd652;
      5'd21: r = 32'sd326;
      5'd22: r = 32'sd163;
      5'd23: r = 32'sd81;
      default: r = 32'sd0;
    endcase
    return r;
  endfunction

endpackage

>>> hdl/slpi_ctrl.sv
// ----------------------------------------------------------------------------
// slpi_ctrl
// Sequencer that steps the datapath through one tick and owns the handshakes.
// ----------------------------------------------------------------------------
module slpi_ctrl #(
  parameter int unsigned CORDIC_STEPS = 16
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic              in_cmd_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output slpi_pkg::dp_cmd_t cmd_o
);

  slpi_pkg::state_e state_q, state_d;
  logic [slpi_pkg::IterW-1:0] iter_q, iter_d;
  logic sel_q, sel_d;
  logic out_valid_q, out_valid_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= slpi_pkg::S_IDLE;
      iter_q      <= '0;
      sel_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      iter_q      <= iter_d;
      sel_q       <= sel_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_stall_o  = (state_q != slpi_pkg::S_IDLE);
  assign out_valid_o = out_valid_q;

  always_comb begin
    state_d     = state_q;
    iter_d      = iter_q;
    sel_d       = sel_q;
    out_valid_d = out_valid_q && out_stall_i;
    cmd_o.op    = slpi_pkg::OP_NONE;
    cmd_o.sel   = sel_q;
    cmd_o.iter  = iter_q;
    case (state_q)
      slpi_pkg::S_IDLE: begin
        if (in_valid_i) begin
          if (in_cmd_i) begin
            cmd_o.op = slpi_pkg::OP_LOAD_DT;
            state_d  = slpi_pkg::S_MUL_LS;
          end else begin
            cmd_o.op = slpi_pkg::OP_STORE;
          end
        end
      end
      slpi_pkg::S_MUL_LS: begin
        cmd_o.op = slpi_pkg::OP_MUL_LS;
        state_d  = slpi_pkg::S_SLEW_L;
      end
      slpi_pkg::S_SLEW_L: begin
        cmd_o.op = slpi_pkg::OP_SLEW_L;
        state_d  = slpi_pkg::S_MUL_AS;
      end
      slpi_pkg::S_MUL_AS: begin
        cmd_o.op = slpi_pkg::OP_MUL_AS;
        state_d  = slpi_pkg::S_SLEW_A;
      end
      slpi_pkg::S_SLEW_A: begin
        cmd_o.op = slpi_pkg::OP_SLEW_A;
        state_d  = slpi_pkg::S_MUL_TH;
      end
      slpi_pkg::S_MUL_TH: begin
        cmd_o.op = slpi_pkg::OP_MUL_TH;
        state_d  = slpi_pkg::S_HEAD;
      end
      slpi_pkg::S_HEAD: begin
        cmd_o.op = slpi_pkg::OP_HEAD;
        iter_d   = '0;
        state_d  = slpi_pkg::S_ROT;
      end
      slpi_pkg::S_ROT: begin
        cmd_o.op = slpi_pkg::OP_ROT;
        iter_d   = iter_q + 1'b1;
        if (iter_q == slpi_pkg::IterW'(CORDIC_STEPS - 1)) begin
          state_d = slpi_pkg::S_FIN;
        end
      end
      slpi_pkg::S_FIN: begin
        cmd_o.op = slpi_pkg::OP_FIN;
        state_d  = slpi_pkg::S_MUL_DS;
      end
      slpi_pkg::S_MUL_DS: begin
        cmd_o.op = slpi_pkg::OP_MUL_DS;
        sel_d    = 1'b0;
        state_d  = slpi_pkg::S_MUL_LO;
      end
      slpi_pkg::S_MUL_LO: begin
        cmd_o.op = slpi_pkg::OP_MUL_LO;
        state_d  = slpi_pkg::S_MUL_HI;
      end
      slpi_pkg::S_MUL_HI: begin
        cmd_o.op = slpi_pkg::OP_MUL_HI;
        state_d  = slpi_pkg::S_POS;
      end
      slpi_pkg::S_POS: begin
        cmd_o.op = slpi_pkg::OP_POS;
        if (sel_q) begin
          state_d = slpi_pkg::S_OUT;
        end else begin
          sel_d   = 1'b1;
          state_d = slpi_pkg::S_MUL_LO;
        end
      end
      slpi_pkg::S_OUT: begin
        // The result register is reloaded once the previous beat has left.
        if (!out_valid_q || !out_stall_i) begin
          cmd_o.op    = slpi_pkg::OP_LOAD_OUT;
          out_valid_d = 1'b1;
          state_d     = slpi_pkg::S_IDLE;
        end
      end
      default: begin
        state_d = slpi_pkg::S_IDLE;
      end
    endcase
  end

endmodule

>>> hdl/slpi_dp.sv
// ----------------------------------------------------------------------------
// slpi_dp
// Datapath: registers, shared multiplier, slew limiters, CORDIC and pose.
// ----------------------------------------------------------------------------
module slpi_dp (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  slpi_pkg::dp_cmd_t   cmd_i,
  input  logic                cfg_wr_en_i,
  input  logic [1:0]          cfg_index_i,
  input  logic [23:0]         cfg_data_i,
  input  logic signed [15:0]  in_target_lin_vel_i,
  input  logic signed [19:0]  in_target_ang_vel_i,
  input  logic [15:0]         in_tick_dt_i,
  output logic signed [31:0]  out_pos_x_o,
  output logic signed [31:0]  out_pos_y_o,
  output logic [15:0]         out_heading_o,
  output logic signed [15:0]  out_lin_vel_o,
  output logic signed [19:0]  out_ang_vel_o
);

  logic [14:0] max_lin_speed_q;
  logic [18:0] max_ang_speed_q;
  logic [19:0] max_lin_accel_q;
  logic [23:0] max_ang_accel_q;

  logic signed [15:0] tar_lin_q, cur_lin_q, cur_lin_d;
  logic signed [19:0] tar_ang_q, cur_ang_q, cur_ang_d;
  logic signed [31:0] pos_x_q, pos_y_q, pos_d;
  logic [15:0] heading_q, heading_d;
  logic [15:0] dt_q;

  logic signed [33:0] x_q, y_q, c_q, s_q, ds_q;
  logic signed [31:0] z_q;
  logic flip_q, flip_d;
  logic signed [51:0] prod_q, lo_q;

  logic signed [33:0] mul_a;
  logic signed [17:0] mul_b;
  logic signed [51:0] prod;
  logic signed [33:0] trig;

  // Linear slew terms.
  logic signed [21:0] l_step, l_cur, l_tar, l_lim, l_up, l_dn, l_res;
  // Angular slew terms.
  logic signed [25:0] a_step, a_cur, a_tar, a_lim, a_up, a_dn, a_res;

  logic [31:0] th_sum;
  logic signed [33:0] x_sh, y_sh;
  logic signed [31:0] at;
  logic signed [65:0] wide;
  logic signed [33:0] pos_sum;
  logic signed [31:0] pos_cur;

  assign trig = cmd_i.sel ? s_q : c_q;

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (cmd_i.op)
      slpi_pkg::OP_MUL_LS: begin
        mul_a = $signed({14'd0, max_lin_accel_q});
        mul_b = $signed({2'd0, dt_q});
      end
      slpi_pkg::OP_MUL_AS: begin
        mul_a = $signed({10'd0, max_ang_accel_q});
        mul_b = $signed({2'd0, dt_q});
      end
      slpi_pkg::OP_MUL_TH: begin
        mul_a = {{14{cur_ang_q[19]}}, cur_ang_q};
        mul_b = $signed({2'd0, dt_q});
      end
      slpi_pkg::OP_MUL_DS: begin
        mul_a = {{18{cur_lin_q[15]}}, cur_lin_q};
        mul_b = $signed({2'd0, dt_q});
      end
      slpi_pkg::OP_MUL_LO: begin
        mul_a = ds_q;
        mul_b = $signed({1'b0, trig[16:0]});
      end
      slpi_pkg::OP_MUL_HI: begin
        mul_a = ds_q;
        mul_b = {trig[33], trig[33:17]};
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign prod = mul_a * mul_b;

  // Slew limiting: the step comes from the registered accel * dt product.
  always_comb begin
    l_step = $signed({2'd0, prod_q[35:16]});
    l_cur  = {{6{cur_lin_q[15]}}, cur_lin_q};
    l_tar  = {{6{tar_lin_q[15]}}, tar_lin_q};
    l_lim  = $signed({7'd0, max_lin_speed_q});
    l_up   = l_cur + l_step;
    l_dn   = l_cur - l_step;
    if (l_tar > l_cur) begin
      l_res = (l_tar < l_lim) ? l_tar : l_lim;
      if (l_up < l_res) l_res = l_up;
    end else if (l_tar < l_cur) begin
      l_res = (l_tar > -l_lim) ? l_tar : -l_lim;
      if (l_dn > l_res) l_res = l_dn;
    end else begin
      l_res = l_tar;
    end
    cur_lin_d = l_res[15:0];

    a_step = $signed({2'd0, prod_q[39:16]});
    a_cur  = {{6{cur_ang_q[19]}}, cur_ang_q};
    a_tar  = {{6{tar_ang_q[19]}}, tar_ang_q};
    a_lim  = $signed({7'd0, max_ang_speed_q});
    a_up   = a_cur + a_step;
    a_dn   = a_cur - a_step;
    if (a_tar > a_cur) begin
      a_res = (a_tar < a_lim) ? a_tar : a_lim;
      if (a_up < a_res) a_res = a_up;
    end else if (a_tar < a_cur) begin
      a_res = (a_tar > -a_lim) ? a_tar : -a_lim;
      if (a_dn > a_res) a_res = a_dn;
    end else begin
      a_res = a_tar;
    end
    cur_ang_d = a_res[19:0];
  end

  // Heading advance, rounded half up to 2^-16 turn.
  assign th_sum    = prod_q[31:0] + 32'h0000_8000;
  assign heading_d = heading_q + th_sum[31:16];
  // Second and third quadrants are rotated by a half turn.
  assign flip_d    = heading_d[15] ^ heading_d[14];

  assign x_sh = x_q >>> cmd_i.iter;
  assign y_sh = y_q >>> cmd_i.iter;
  assign at   = slpi_pkg::atan_turn(cmd_i.iter);

  // Position increment: (hi << 17) + lo, rounded half up from 2^-42.
  assign wide    = ({{14{prod_q[51]}}, prod_q} <<< 17) + {{14{lo_q[51]}}, lo_q}
                   + 66'sh200_0000_0000;
  assign pos_cur = cmd_i.sel ? pos_y_q : pos_x_q;
  assign pos_sum = {{2{pos_cur[31]}}, pos_cur} + {{10{wide[65]}}, wide[65:42]};

  always_comb begin
    if (pos_sum[33:31] == 3'b000 || pos_sum[33:31] == 3'b111) begin
      pos_d = pos_sum[31:0];
    end else if (pos_sum[33]) begin
      pos_d = 32'sh8000_0000;
    end else begin
      pos_d = 32'sh7FFF_FFFF;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_lin_speed_q <= slpi_pkg::MaxLinSpeedRst;
      max_ang_speed_q <= slpi_pkg::MaxAngSpeedRst;
      max_lin_accel_q <= slpi_pkg::MaxLinAccelRst;
      max_ang_accel_q <= slpi_pkg::MaxAngAccelRst;
      tar_lin_q       <= '0;
      tar_ang_q       <= '0;
      cur_lin_q       <= '0;
      cur_ang_q       <= '0;
      pos_x_q         <= '0;
      pos_y_q         <= '0;
      heading_q       <= '0;
    end else begin
      if (cfg_wr_en_i) begin
        case (slpi_pkg::reg_idx_e'(cfg_index_i))
          slpi_pkg::REG_MAX_LIN_SPEED: max_lin_speed_q <= cfg_data_i[14:0];
          slpi_pkg::REG_MAX_ANG_SPEED: max_ang_speed_q <= cfg_data_i[18:0];
          slpi_pkg::REG_MAX_LIN_ACCEL: max_lin_accel_q <= cfg_data_i[19:0];
          slpi_pkg::REG_MAX_ANG_ACCEL: max_ang_accel_q <= cfg_data_i[23:0];
          default: ;
        endcase
      end
      case (cmd_i.op)
        slpi_pkg::OP_STORE: begin
          tar_lin_q <= in_target_lin_vel_i;
          tar_ang_q <= in_target_ang_vel_i;
        end
        slpi_pkg::OP_SLEW_L: cur_lin_q <= cur_lin_d;
        slpi_pkg::OP_SLEW_A: cur_ang_q <= cur_ang_d;
        slpi_pkg::OP_HEAD:   heading_q <= heading_d;
        slpi_pkg::OP_POS: begin
          if (cmd_i.sel) pos_y_q <= pos_d;
          else           pos_x_q <= pos_d;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    case (cmd_i.op)
      slpi_pkg::OP_LOAD_DT: dt_q <= in_tick_dt_i;
      slpi_pkg::OP_MUL_LS, slpi_pkg::OP_MUL_AS, slpi_pkg::OP_MUL_TH,
      slpi_pkg::OP_MUL_LO: prod_q <= prod;
      slpi_pkg::OP_MUL_HI: begin
        lo_q   <= prod_q;
        prod_q <= prod;
      end
      slpi_pkg::OP_MUL_DS: ds_q <= prod[33:0];
      slpi_pkg::OP_HEAD: begin
        x_q    <= slpi_pkg::CordicGain;
        y_q    <= '0;
        flip_q <= flip_d;
        z_q    <= $signed({heading_d[15] ^ flip_d, heading_d[14:0], 16'd0});
      end
      slpi_pkg::OP_ROT: begin
        if (!z_q[31]) begin
          x_q <= x_q - y_sh;
          y_q <= y_q + x_sh;
          z_q <= z_q - at;
        end else begin
          x_q <= x_q + y_sh;
          y_q <= y_q - x_sh;
          z_q <= z_q + at;
        end
      end
      slpi_pkg::OP_FIN: begin
        c_q <= flip_q ? -x_q : x_q;
        s_q <= flip_q ? -y_q : y_q;
      end
      slpi_pkg::OP_LOAD_OUT: begin
        out_pos_x_o   <= pos_x_q;
        out_pos_y_o   <= pos_y_q;
        out_heading_o <= heading_q;
        out_lin_vel_o <= cur_lin_q;
        out_ang_vel_o <= cur_ang_q;
      end
      default: ;
    endcase
  end

endmodule

>>> hdl/slew_limited_pose_integrator_unit.sv
// ----------------------------------------------------------------------------
// slew_limited_pose_integrator_unit
// Unicycle dead reckoning with slew-limited velocities and CORDIC trig.
// ----------------------------------------------------------------------------
// A store beat updates the targets and gives no result. A tick beat keeps
// in_stall_o high until its pose is loaded into the output registers, which
// waits while a stalled result is still held. A tick does one CORDIC rotation
// per cycle and uses the single shared multiplier. Reset restores the register
// defaults and clears targets, velocities, pose and the sequencer state only.
module slew_limited_pose_integrator_unit #(
  parameter int unsigned CORDIC_STEPS = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_wr_en_i,
  input  logic [1:0]         cfg_index_i,
  input  logic [23:0]        cfg_data_i,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic               in_cmd_i,
  input  logic signed [15:0] in_target_lin_vel_i,
  input  logic signed [19:0] in_target_ang_vel_i,
  input  logic [15:0]        in_tick_dt_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic signed [31:0] out_pos_x_o,
  output logic signed [31:0] out_pos_y_o,
  output logic [15:0]        out_heading_o,
  output logic signed [15:0] out_lin_vel_o,
  output logic signed [19:0] out_ang_vel_o
);

  slpi_pkg::dp_cmd_t dp_cmd;

  slpi_ctrl #(
    .CORDIC_STEPS(CORDIC_STEPS)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_cmd_i    (in_cmd_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .cmd_o       (dp_cmd)
  );

  slpi_dp u_dp (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .cmd_i               (dp_cmd),
    .cfg_wr_en_i         (cfg_wr_en_i),
    .cfg_index_i         (cfg_index_i),
    .cfg_data_i          (cfg_data_i),
    .in_target_lin_vel_i (in_target_lin_vel_i),
    .in_target_ang_vel_i (in_target_ang_vel_i),
    .in_tick_dt_i        (in_tick_dt_i),
    .out_pos_x_o         (out_pos_x_o),
    .out_pos_y_o         (out_pos_y_o),
    .out_heading_o       (out_heading_o),
    .out_lin_vel_o       (out_lin_vel_o),
    .out_ang_vel_o       (out_ang_vel_o)
  );

endmodule

>>> test/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking regression of the slew-limited pose integrator. A behavioral
// predictor tracks targets, velocities and pose; each result beat is compared
// with the oldest predicted pose under random sender and receiver idling.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;

  localparam int unsigned Steps = 16;
  localparam int unsigned TickCycles = Steps + 16;
  localparam longint CycleLimit = 3000000;

  typedef struct packed {
    logic signed [31:0] px;
    logic signed [31:0] py;
    logic [15:0]        hd;
    logic signed [15:0] lv;
    logic signed [19:0] av;
  } pose_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_wr_en_i = 1'b0;
  logic [1:0] cfg_index_i = '0;
  logic [23:0] cfg_data_i = '0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  logic in_cmd_i = 1'b0;
  logic signed [15:0] in_target_lin_vel_i = '0;
  logic signed [19:0] in_target_ang_vel_i = '0;
  logic [15:0] in_tick_dt_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  logic signed [31:0] out_pos_x_o, out_pos_y_o;
  logic [15:0] out_heading_o;
  logic signed [15:0] out_lin_vel_o;
  logic signed [19:0] out_ang_vel_o;

  slew_limited_pose_integrator_unit #(.CORDIC_STEPS(Steps)) dut (.*);

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // Predictor state and configuration.
  longint lim_lin, lim_ang, acc_lin, acc_ang;
  longint tgt_lin, tgt_ang, vel_lin, vel_ang, pos_x, pos_y;
  int unsigned head;
  pose_t pose_q[$];
  int send_idle_pct, recv_stall_pct;
  int mismatches;
  longint cycles;
  bit timed_out;

  function automatic longint fshr(longint v, int s);
    return v >>> s;
  endfunction

  function automatic longint slew_to(longint cur, longint tar, longint lim, longint stp);
    longint r;
    if (tar > cur) begin
      r = tar < lim ? tar : lim;
      r = r < cur + stp ? r : cur + stp;
    end else if (tar < cur) begin
      r = tar > -lim ? tar : -lim;
      r = r > cur - stp ? r : cur - stp;
    end else begin
      r = tar;
    end
    return r;
  endfunction

  function automatic longint sat32(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic longint atan_of(int i);
    longint t[24] = '{536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
                      10679838, 5340245, 2670163, 1335087, 667544, 333772,
                      166886, 83443, 41722, 20861, 10430, 5215,
                      2608, 1304, 652, 326, 163, 81};
    return t[i];
  endfunction

  task automatic rotate(input int unsigned ang, output longint c, output longint s);
    logic [31:0] z;
    logic [1:0] q;
    bit flip;
    longint x, y, zz, nx;
    z = {ang[15:0], 16'h0};
    q = z[31:30];
    flip = (q == 2'd1 || q == 2'd2);
    if (flip) z = z + 32'h8000_0000;
    zz = longint'(signed'(z));
    x = 652032874;
    y = 0;
    for (int i = 0; i < Steps; i++) begin
      if (zz >= 0) begin
        nx = x - fshr(y, i); y = y + fshr(x, i); zz -= atan_of(i);
      end else begin
        nx = x + fshr(y, i); y = y - fshr(x, i); zz += atan_of(i);
      end
      x = nx;
    end
    c = flip ? -x : x;
    s = flip ? -y : y;
  endtask

  task automatic predict_tick(input logic [15:0] dtv);
    longint dt, c, s, ds, dth;
    pose_t p;
    dt = longint'(dtv);
    vel_lin = slew_to(vel_lin, tgt_lin, lim_lin, (acc_lin * dt) >>> 16);
    vel_ang = slew_to(vel_ang, tgt_ang, lim_ang, (acc_ang * dt) >>> 16);
    dth = fshr(vel_ang * dt + 64'sh8000, 16);
    head = (head + int'(dth)) & 32'hFFFF;
    rotate(head, c, s);
    ds = vel_lin * dt;
    pos_x = sat32(pos_x + fshr(ds * c + (64'sd1 <<< 41), 42));
    pos_y = sat32(pos_y + fshr(ds * s + (64'sd1 <<< 41), 42));
    p.px = pos_x[31:0]; p.py = pos_y[31:0]; p.hd = head[15:0];
    p.lv = vel_lin[15:0]; p.av = vel_ang[19:0];
    pose_q.push_back(p);
  endtask

  // Sends one beat and updates the predictor when it is accepted. Valid
  // stays high after acceptance until the sender idles or the stream drains.
  task automatic send_beat(input bit cmd, input logic [15:0] lin,
                           input logic [19:0] ang, input logic [15:0] dtv);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_cmd_i <= cmd;
    in_target_lin_vel_i <= lin;
    in_target_ang_vel_i <= ang;
    in_tick_dt_i <= dtv;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    if (cmd) predict_tick(dtv);
    else begin
      tgt_lin = longint'(signed'(lin));
      tgt_ang = longint'(signed'(ang));
    end
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    while (pose_q.size() != 0) @(posedge clk_i);
    repeat (TickCycles + 4) @(posedge clk_i);
  endtask

  task automatic write_reg(input slpi_pkg::reg_idx_e idx, input logic [23:0] val);
    cfg_wr_en_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    case (idx)
      slpi_pkg::REG_MAX_LIN_SPEED: lim_lin = longint'(val[14:0]);
      slpi_pkg::REG_MAX_ANG_SPEED: lim_ang = longint'(val[18:0]);
      slpi_pkg::REG_MAX_LIN_ACCEL: acc_lin = longint'(val[19:0]);
      slpi_pkg::REG_MAX_ANG_ACCEL: acc_ang = longint'(val[23:0]);
      default: ;
    endcase
  endtask

  task automatic set_limits(input logic [23:0] a, b, c, d);
    write_reg(slpi_pkg::REG_MAX_LIN_SPEED, a);
    write_reg(slpi_pkg::REG_MAX_ANG_SPEED, b);
    write_reg(slpi_pkg::REG_MAX_LIN_ACCEL, c);
    write_reg(slpi_pkg::REG_MAX_ANG_ACCEL, d);
    cfg_wr_en_i <= 1'b0;
  endtask

  task automatic rand_store();
    send_beat(1'b0, 16'($urandom), 20'($urandom), 16'($urandom));
  endtask

  // Short dt keeps the pose from saturating at once; some ticks use any dt.
  task automatic rand_tick();
    logic [15:0] d;
    case ($urandom_range(9))
      0: d = 16'd0;
      1: d = 16'hFFFF;
      2, 3: d = 16'($urandom);
      default: d = 16'($urandom_range(4095));
    endcase
    send_beat(1'b1, 16'($urandom), 20'($urandom), d);
  endtask

  task automatic test_directed();
    send_beat(1'b1, '0, '0, 16'd1000);
    send_beat(1'b0, 16'sh7FFF, 20'sh7FFFF, '0);
    send_beat(1'b1, '0, '0, 16'd0);
    send_beat(1'b1, '0, '0, 16'hFFFF);
    send_beat(1'b1, '0, '0, 16'd300);
    send_beat(1'b0, 16'sh8000, 20'sh80000, 16'hFFFF);
    send_beat(1'b1, '0, '0, 16'hFFFF);
    send_beat(1'b1, '0, '0, 16'hFFFF);
    send_beat(1'b0, 16'sd100, -20'sd50, '0);
    send_beat(1'b1, 16'hFFFF, 20'hFFFFF, 16'd0);
    send_beat(1'b1, '0, '0, 16'd2);
    drain();
    // Lowered limits are set while both velocities lie beyond the new speed limits.
    set_limits(24'd10, 24'd20, 24'hFFFFFF, 24'hFFFFFF);
    send_beat(1'b0, 16'sd2000, -20'sd3000, '0);
    send_beat(1'b1, '0, '0, 16'd5);
    send_beat(1'b0, -16'sd2000, 20'sd3000, '0);
    send_beat(1'b1, '0, '0, 16'd5);
    drain();
    set_limits(24'd0, 24'd0, 24'd0, 24'd0);
    send_beat(1'b1, '0, '0, 16'hFFFF);
    drain();
  endtask

  task automatic test_random(input int n);
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(2) == 0) rand_store();
      else rand_tick();
    end
  endtask

  task automatic test_phases();
    int pct[4][2] = '{'{0, 0}, '{46, 0}, '{0, 46}, '{27, 27}};
    for (int ph = 0; ph < 8; ph++) begin
      send_idle_pct = pct[ph % 4][0];
      recv_stall_pct = pct[ph % 4][1];
      case (ph)
        0: set_limits(24'h7FFF, 24'h7FFFF, 24'hFFFFF, 24'hFFFFFF);
        3: set_limits(24'd0, 24'd1, 24'd0, 24'd1);
        5: set_limits(24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF);
        default: set_limits(24'($urandom), 24'($urandom), 24'($urandom_range(4095)),
                            24'($urandom));
      endcase
      test_random(115);
      drain();
      test_random(115);
      drain();
    end
  endtask

  initial begin
    lim_lin = longint'(slpi_pkg::MaxLinSpeedRst);
    lim_ang = longint'(slpi_pkg::MaxAngSpeedRst);
    acc_lin = longint'(slpi_pkg::MaxLinAccelRst);
    acc_ang = longint'(slpi_pkg::MaxAngAccelRst);
    tgt_lin = 0; tgt_ang = 0; vel_lin = 0; vel_ang = 0;
    pos_x = 0; pos_y = 0; head = 0;
    send_idle_pct = 0; recv_stall_pct = 0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_phases();
    drain();
    if (mismatches == 0 && pose_q.size() == 0) begin
      $display("slew_limited_pose_integrator_unit regression: pass");
    end else begin
      $display("slew_limited_pose_integrator_unit regression: fail");
    end
    $finish;
  end

  always @(posedge clk_i) begin
    out_stall_i <= ($urandom_range(99) < recv_stall_pct);
  end

  always @(posedge clk_i) begin
    pose_t got, want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      got = {out_pos_x_o, out_pos_y_o, out_heading_o, out_lin_vel_o, out_ang_vel_o};
      if (pose_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result beat %h", got);
      end else begin
        want = pose_q.pop_front();
        if (got !== want) begin
          mismatches++;
          if (mismatches <= 10)
            $display("pose mismatch: x %0d/%0d y %0d/%0d hd %0d/%0d lv %0d/%0d av %0d/%0d",
                     want.px, got.px, want.py, got.py, want.hd, got.hd,
                     want.lv, got.lv, want.av, got.av);
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CycleLimit && !timed_out) begin
      timed_out = 1'b1;
      $display("slew_limited_pose_integrator_unit regression: fail");
      $finish;
    end
  end

endmodule

>>> slew_limited_pose_integrator_unit.f
hdl/slpi_pkg.sv
hdl/slpi_ctrl.sv
hdl/slpi_dp.sv
hdl/slew_limited_pose_integrator_unit.sv
test/tb.sv
